>>> rtl/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

>>> rtl/tcpm_pkg.sv
package tcpm_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int RUN_W           = $clog2(MAX_RESULTS);

    localparam logic [7:0] THRESHOLD_RESET = 8'd60;

    localparam logic CMD_PRESENT = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;

    localparam logic [1:0] KIND_PAIR     = 2'd0;
    localparam logic [1:0] KIND_UNP_HIGH = 2'd1;
    localparam logic [1:0] KIND_UNP_LOW  = 2'd2;
    localparam logic [1:0] KIND_DROPPED  = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [15:0] item_id;
        logic [7:0]  score;
    } t_in;

    typedef struct packed {
        logic [15:0] high_id;
        logic [15:0] low_id;
        logic [1:0]  kind;
        logic        last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAIR,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [15:0] wr_id;
        logic        wr_high;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
        logic wait_high;
    } t_q_stat;

endpackage

>>> rtl/two_class_fifo_pair_matcher.sv
// A pair reaches o_res via ST_PAIR; a drop shows on o_res in the cycle after start.
// A queued item gives no result; busy stays low, so the next item may start at once.
// One present item per cycle when queued; a paired item keeps busy high in ST_PAIR.
// A flush of N waiting items emits one result per cycle from the FIFO memory.
// Synchronous active-low reset empties the queue and sets the threshold to 60.
// The receiver cannot stall; o_res_valid marks each result for exactly one cycle.
module two_class_fifo_pair_matcher import tcpm_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_in        i_in,
    output logic       busy,
    output logic       o_res_valid,
    output t_res       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_state           r_state, n_state;
    logic [7:0]       r_thresh;
    logic [15:0]      r_cur_id, n_cur_id;
    logic             r_cur_high, n_cur_high;
    logic [RUN_W-1:0] r_run, n_run;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    t_q_ctrl     q_ctrl;
    t_q_stat     q_stat;
    logic [15:0] q_rd_id;

    logic accept;
    logic in_high;
    logic flush_fin;

    tcpm_store #(
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (q_ctrl),
        .o_stat (q_stat),
        .o_rd_id(q_rd_id)
    );

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign in_high     = (i_in.score >= r_thresh);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // The entry shown by the store was popped last cycle; the run ends when the
    // queue is now empty or the per-flush limit is reached.
    assign flush_fin = q_stat.empty || (r_run == RUN_W'(MAX_RESULTS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.cmd == CMD_FLUSH) begin
                        n_state = q_stat.empty ? ST_IDLE : ST_FLUSH;
                    end else if (!q_stat.empty && (q_stat.wait_high != in_high)) begin
                        n_state = ST_PAIR;
                    end
                end
            end
            ST_PAIR: begin
                n_state = ST_IDLE;
            end
            ST_FLUSH: begin
                if (flush_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        q_ctrl      = '0;
        q_ctrl.wr_id   = i_in.item_id;
        q_ctrl.wr_high = in_high;
        n_cur_id    = r_cur_id;
        n_cur_high  = r_cur_high;
        n_run       = r_run;
        n_out_valid = 1'b0;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cur_id   = i_in.item_id;
                    n_cur_high = in_high;
                    n_run      = '0;
                    if (i_in.cmd == CMD_FLUSH) begin
                        q_ctrl.pop = !q_stat.empty;
                    end else if (!q_stat.empty && (q_stat.wait_high != in_high)) begin
                        q_ctrl.pop = 1'b1;
                    end else if (!q_stat.full) begin
                        q_ctrl.push = 1'b1;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out.kind   = KIND_DROPPED;
                        n_out.last   = 1'b1;
                        n_out.high_id = in_high ? i_in.item_id : '0;
                        n_out.low_id  = in_high ? '0 : i_in.item_id;
                    end
                end
            end
            ST_PAIR: begin
                n_out_valid   = 1'b1;
                n_out.kind    = KIND_PAIR;
                n_out.last    = 1'b1;
                n_out.high_id = r_cur_high ? r_cur_id : q_rd_id;
                n_out.low_id  = r_cur_high ? q_rd_id : r_cur_id;
            end
            ST_FLUSH: begin
                n_out_valid   = 1'b1;
                n_out.kind    = q_stat.wait_high ? KIND_UNP_HIGH : KIND_UNP_LOW;
                n_out.last    = flush_fin;
                n_out.high_id = q_stat.wait_high ? q_rd_id : '0;
                n_out.low_id  = q_stat.wait_high ? '0 : q_rd_id;
                if (!flush_fin) begin
                    q_ctrl.pop = 1'b1;
                    n_run      = r_run + 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thresh    <= THRESHOLD_RESET;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_id   <= n_cur_id;
        r_cur_high <= n_cur_high;
        r_out      <= n_out;
    end

endmodule

>>> rtl/tcpm_store.sv
module tcpm_store import tcpm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_ctrl     i_ctrl,
    output t_q_stat     o_stat,
    output logic [15:0] o_rd_id
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [15:0]      r_mem [DEPTH];
    logic [15:0]      r_rd_data;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_wait_high, n_wait_high;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_wait_high = r_wait_high;
        if (i_ctrl.push) begin
            n_wr_ptr    = ptr_inc(r_wr_ptr);
            n_count     = r_count + 1'b1;
            n_wait_high = i_ctrl.wr_high;
        end else if (i_ctrl.pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_wait_high <= 1'b0;
        end else begin
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_wait_high <= n_wait_high;
        end
    end

    // Single-port storage: the controller never pushes and pops in one cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wr_ptr] <= i_ctrl.wr_id;
        end
        if (i_ctrl.pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.wait_high = r_wait_high;
    assign o_rd_id          = r_rd_data;

endmodule

>>> rtl/tcpm_checker.sv
`include "assert_macros.svh"

module tcpm_checker import tcpm_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_res_valid,
    input t_res o_res
);

    logic mid_run;
    logic single_res;
    logic one_id;

    assign mid_run    = o_res_valid && !o_res.last;
    assign single_res = o_res_valid &&
                        (o_res.kind inside {KIND_UNP_HIGH, KIND_UNP_LOW, KIND_DROPPED});
    assign one_id     = (o_res.high_id == '0) || (o_res.low_id == '0);

    // A flush run emits its results on consecutive cycles until the marked one.
    `ASSERT_CLK_RST(a_run_contiguous, i_clk, i_rst_n, mid_run |=> o_res_valid, "run broke early")

    // While a run is still going, no new item may be taken.
    `ASSERT_CLK_RST(a_run_busy, i_clk, i_rst_n, mid_run |-> busy, "idle during a run")

    // An unpaired or dropped item fills only one id field.
    `ASSERT_CLK_RST(a_single_id, i_clk, i_rst_n, single_res |-> one_id, "two ids in one result")

    // The block only turns busy right after it took an item.
    `ASSERT_CLK_RST(a_busy_src, i_clk, i_rst_n, $rose(busy) |-> $past(start), "stray busy")

    // Reset suppresses the result strobe on the following cycle.
    `ASSERT_CLK(a_reset_quiet, i_clk, !i_rst_n |=> !o_res_valid, "strobe after reset")

endmodule

bind two_class_fifo_pair_matcher tcpm_checker u_tcpm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_res_valid(o_res_valid),
    .o_res      (o_res)
);
